[design/lcsq_pkg.sv]
package lcsq_pkg;

  localparam int unsigned MASK_W   = 4;
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned CONF_W   = 24;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned OUT_LEGS = 4;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 16'h8000;

  localparam logic              RST_MOD_ENABLE = 1'b1;
  localparam logic [GAIN_W-1:0] RST_SLIP_GAIN  = 16'd16384;
  localparam logic [TICK_W-1:0] RST_TICK_US    = 16'd2500;
  localparam logic [CONF_W-1:0] RST_CONFIRM_US = 24'd30000;
  localparam logic [CONF_W-1:0] RST_RECOVER_US = 24'd500000;

  typedef enum logic [2:0] {
    REG_MOD_ENABLE = 3'd0,
    REG_SLIP_GAIN  = 3'd1,
    REG_TICK_US    = 3'd2,
    REG_CONFIRM_US = 3'd3,
    REG_RECOVER_US = 3'd4
  } cfg_reg_e;

  // Settings shared by every leg lane.
  typedef struct packed {
    logic              enable;
    logic [TICK_W-1:0] tick;
    logic [CONF_W-1:0] confirm;
    logic [CONF_W-1:0] recover;
    logic [GAIN_W-1:0] sgain;
  } lane_cfg_t;

  typedef struct packed {
    logic [MASK_W-1:0]                liftoff;
    logic [MASK_W-1:0]                touchdown;
    logic [TIME_W-1:0]                event_time;
    logic [OUT_LEGS-1:0][GAIN_W-1:0]  gains;
  } res_t;

endpackage

[design/lcsq_lane.sv]
module lcsq_lane #(
  parameter int unsigned TIMER_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          upd_i,
  input  lcsq_pkg::lane_cfg_t           cfg_i,
  input  logic                          grounded_i,
  input  logic                          slipping_i,
  output logic [lcsq_pkg::GAIN_W-1:0]   gain_o
);
  import lcsq_pkg::*;

  localparam int unsigned CMP_W = (TIMER_BITS > CONF_W) ? TIMER_BITS : CONF_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  logic [TIMER_BITS-1:0] stance_q, stance_d;
  logic [TIMER_BITS-1:0] noslip_q, noslip_d;
  logic                  latched_q, latched_d;
  logic [GAIN_W-1:0]     gain_q, gain_d;
  logic [TIMER_BITS:0]   stance_sum, noslip_sum;
  logic [TIMER_BITS-1:0] stance_inc, noslip_inc;
  logic                  upd;

  // Saturating increments of both timers by one tick.
  assign stance_sum = {1'b0, stance_q} + (TIMER_BITS+1)'(cfg_i.tick);
  assign noslip_sum = {1'b0, noslip_q} + (TIMER_BITS+1)'(cfg_i.tick);
  assign stance_inc = stance_sum[TIMER_BITS] ? TIMER_MAX : stance_sum[TIMER_BITS-1:0];
  assign noslip_inc = noslip_sum[TIMER_BITS] ? TIMER_MAX : noslip_sum[TIMER_BITS-1:0];

  assign upd = upd_i & cfg_i.enable;

  always_comb begin
    stance_d  = grounded_i ? stance_inc : '0;
    noslip_d  = noslip_q;
    latched_d = latched_q;
    gain_d    = gain_q;
    if (latched_q && grounded_i) begin
      noslip_d = slipping_i ? '0 : noslip_inc;
    end
    if (slipping_i) begin
      if (CMP_W'(stance_d) > CMP_W'(cfg_i.confirm)) begin
        gain_d    = cfg_i.sgain;
        latched_d = 1'b1;
      end
    end else if (grounded_i && latched_q) begin
      if (CMP_W'(noslip_d) > CMP_W'(cfg_i.recover)) begin
        gain_d    = GAIN_ONE;
        latched_d = 1'b0;
        noslip_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stance_q  <= '0;
      noslip_q  <= '0;
      latched_q <= 1'b0;
      gain_q    <= GAIN_ONE;
    end else if (upd) begin
      stance_q  <= stance_d;
      noslip_q  <= noslip_d;
      latched_q <= latched_d;
      gain_q    <= gain_d;
    end
  end

  assign gain_o = gain_q;

endmodule

[design/lcsq_outbuf.sv]
module lcsq_outbuf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lcsq_pkg::res_t data_i,
  output logic           ready_o,
  output logic           valid_o,
  input  logic           ready_i,
  output lcsq_pkg::res_t data_o
);
  import lcsq_pkg::*;

  logic out_valid_q, skid_valid_q;
  res_t out_data_q, skid_data_q;
  logic pop;

  assign pop     = out_valid_q & ready_i;
  assign ready_o = ~skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= push_i;
      end else begin
        out_valid_q  <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_data_q <= skid_data_q;
        if (push_i) begin
          skid_data_q <= data_i;
        end
      end else if (push_i) begin
        out_data_q <= data_i;
      end
    end else if (push_i) begin
      skid_data_q <= data_i;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  // The skid entry is only ever occupied behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid while output register empty");

  // A beat pushed while the output stalls must land in the skid entry.
  a_stall_push_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && out_valid_q && !ready_i) |=> skid_valid_q)
    else $error("beat lost while output stalled");

  // Draining the skid entry moves its beat to the output register.
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && pop) |=> (out_valid_q && out_data_q == $past(skid_data_q)))
    else $error("skid beat not forwarded to output");
`endif

endmodule

[design/leg_contact_slip_qualifier_top.sv]
// Leg contact and slip qualifier. Each input beat is one control tick with a
// grounded bit and a slipping bit per leg; it produces exactly one output beat
// with lift-off and touch-down edge masks, the microsecond time stamp after
// the tick, and the friction gain of each leg in unsigned Q1.15. One leg lane
// per leg, up to four, runs its stance and no-slip timers and slip latch side
// by side; the top level merges the lanes with the edge masks and the clock.
// A tick is accepted every cycle unless the output stalls; the lanes take it
// at accept, as the next tick needs their timers; its result is registered
// ahead of a two-entry output buffer, which lets the block take one more tick
// while a result waits, after which in_ready_o drops until the output drains.
// Configuration goes through the APB-style port at byte addresses 0, 4, 8, 12
// and 16 (modulation enable, slip gain, tick length, slip confirm time and
// recovery time) and must be written only while the block is idle. Writing
// zero to the modulation enable freezes timers, latches and gains while the
// clock and the edge detection keep running.
module leg_contact_slip_qualifier_top #(
  parameter int unsigned NUM_LEGS   = 4,
  parameter int unsigned TIMER_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lcsq_pkg::ADDR_W-1:0]   paddr,
  input  logic [lcsq_pkg::DATA_W-1:0]   pwdata,
  output logic [lcsq_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lcsq_pkg::MASK_W-1:0]   grounded_mask_i,
  input  logic [lcsq_pkg::MASK_W-1:0]   slipping_mask_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lcsq_pkg::MASK_W-1:0]   liftoff_mask_o,
  output logic [lcsq_pkg::MASK_W-1:0]   touchdown_mask_o,
  output logic [lcsq_pkg::TIME_W-1:0]   event_time_o,
  output logic [lcsq_pkg::GAIN_W-1:0]   gain_leg0_o,
  output logic [lcsq_pkg::GAIN_W-1:0]   gain_leg1_o,
  output logic [lcsq_pkg::GAIN_W-1:0]   gain_leg2_o,
  output logic [lcsq_pkg::GAIN_W-1:0]   gain_leg3_o
);
  import lcsq_pkg::*;

  // Legs beyond the fourth never see a grounded or slipping bit, so their
  // state can never reach an output; only the first four get a lane.
  localparam int unsigned LANES = (NUM_LEGS < OUT_LEGS) ? NUM_LEGS : OUT_LEGS;

  // Configuration registers.
  logic              mod_enable_q;
  logic [GAIN_W-1:0] slip_gain_q;
  logic [TICK_W-1:0] tick_us_q;
  logic [CONF_W-1:0] confirm_us_q;
  logic [CONF_W-1:0] recover_us_q;

  cfg_reg_e  reg_sel;
  logic      cfg_wr;
  lane_cfg_t lane_cfg;

  logic [TIME_W-1:0]  elapsed_q, elapsed_d;
  logic [LANES-1:0]   prev_gnd_q;
  logic [LANES-1:0]   gnd, slp;
  logic [LANES-1:0][GAIN_W-1:0] lane_gain;
  logic               in_fire;
  res_t               res_d, res_q;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_enable_q <= RST_MOD_ENABLE;
      slip_gain_q  <= RST_SLIP_GAIN;
      tick_us_q    <= RST_TICK_US;
      confirm_us_q <= RST_CONFIRM_US;
      recover_us_q <= RST_RECOVER_US;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_MOD_ENABLE: mod_enable_q <= pwdata[0];
        REG_SLIP_GAIN:  slip_gain_q  <= pwdata[GAIN_W-1:0];
        REG_TICK_US:    tick_us_q    <= pwdata[TICK_W-1:0];
        REG_CONFIRM_US: confirm_us_q <= pwdata[CONF_W-1:0];
        REG_RECOVER_US: recover_us_q <= pwdata[CONF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MOD_ENABLE: prdata = DATA_W'(mod_enable_q);
      REG_SLIP_GAIN:  prdata = DATA_W'(slip_gain_q);
      REG_TICK_US:    prdata = DATA_W'(tick_us_q);
      REG_CONFIRM_US: prdata = DATA_W'(confirm_us_q);
      REG_RECOVER_US: prdata = DATA_W'(recover_us_q);
      default:        prdata = '0;
    endcase
  end

  // Slip gain values above one are clamped to one when they are latched.
  assign lane_cfg.enable  = mod_enable_q;
  assign lane_cfg.tick    = tick_us_q;
  assign lane_cfg.confirm = confirm_us_q;
  assign lane_cfg.recover = recover_us_q;
  assign lane_cfg.sgain   = (slip_gain_q > GAIN_ONE) ? GAIN_ONE : slip_gain_q;

  assign in_fire   = in_valid_i & in_ready_o;
  assign gnd       = grounded_mask_i[LANES-1:0];
  assign slp       = slipping_mask_i[LANES-1:0];
  assign elapsed_d = elapsed_q + TIME_W'(tick_us_q);

  // The microsecond clock wraps naturally at its width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q  <= '0;
      prev_gnd_q <= '0;
    end else if (in_fire) begin
      elapsed_q  <= elapsed_d;
      prev_gnd_q <= gnd;
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    lcsq_lane #(
      .TIMER_BITS (TIMER_BITS)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .upd_i      (in_fire),
      .cfg_i      (lane_cfg),
      .grounded_i (gnd[i]),
      .slipping_i (slp[i]),
      .gain_o     (lane_gain[i])
    );
  end

  // Merge: the edges come from the tick itself, while the gains are read
  // from the lanes once they have taken this tick, in the cycle after accept.
  always_comb begin
    res_d.liftoff    = '0;
    res_d.touchdown  = '0;
    res_d.event_time = elapsed_d;
    res_d.gains      = res_q.gains;
    res_d.liftoff[LANES-1:0]   = prev_gnd_q & ~gnd;
    res_d.touchdown[LANES-1:0] = ~prev_gnd_q & gnd;
  end

  // The edge masks and time stamp are registered at accept; the lane gains
  // settle at the same edge, so the beat is completed with them the cycle after.
  logic       res_pend_q;
  res_t       res_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_pend_q <= 1'b0;
    end else begin
      res_pend_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  for (genvar i = 0; i < OUT_LEGS; i++) begin : g_gain
    if (i < LANES) begin : g_used
      assign res_full.gains[i] = lane_gain[i];
    end else begin : g_fixed
      assign res_full.gains[i] = GAIN_ONE;
    end
  end
  assign res_full.liftoff    = res_q.liftoff;
  assign res_full.touchdown  = res_q.touchdown;
  assign res_full.event_time = res_q.event_time;

  // The buffer holds two beats; one sits in the gain-merge stage, so input
  // is taken only while the buffer could absorb both.
  logic buf_ready;
  logic buf_has_one;

  lcsq_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_pend_q),
    .data_i  (res_full),
    .ready_o (buf_ready),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  ({liftoff_mask_o, touchdown_mask_o, event_time_o,
               gain_leg3_o, gain_leg2_o, gain_leg1_o, gain_leg0_o})
  );

  assign buf_has_one = out_valid_o & ~out_ready_i;
  assign in_ready_o  = buf_ready & ~(res_pend_q & buf_has_one);

endmodule

[verif/lcsq_checker.sv]
`timescale 1ns / 100ps

// Watches the configuration port and both beat channels of the leg contact and
// slip qualifier. It keeps its own copy of the registers and the per-leg state,
// predicts the result of every accepted tick and compares each result beat,
// field by field, with the oldest prediction.
module lcsq_checker #(
  parameter int unsigned NUM_LEGS   = 4,
  parameter int unsigned TIMER_BITS = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [lcsq_pkg::ADDR_W-1:0] paddr,
  input  logic [lcsq_pkg::DATA_W-1:0] pwdata,
  input  logic [lcsq_pkg::DATA_W-1:0] prdata,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [lcsq_pkg::MASK_W-1:0] grounded_mask_i,
  input  logic [lcsq_pkg::MASK_W-1:0] slipping_mask_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [lcsq_pkg::MASK_W-1:0] liftoff_mask_i,
  input  logic [lcsq_pkg::MASK_W-1:0] touchdown_mask_i,
  input  logic [lcsq_pkg::TIME_W-1:0] event_time_i,
  input  logic [lcsq_pkg::GAIN_W-1:0] gain_leg0_i,
  input  logic [lcsq_pkg::GAIN_W-1:0] gain_leg1_i,
  input  logic [lcsq_pkg::GAIN_W-1:0] gain_leg2_i,
  input  logic [lcsq_pkg::GAIN_W-1:0] gain_leg3_i,
  output int unsigned                 mismatch_count_o,
  output int unsigned                 ticks_in_flight_o,
  output int unsigned                 results_checked_o
);
  import lcsq_pkg::*;

  lane_cfg_t             cfg;
  logic [TIME_W-1:0]     clock_us;
  logic [MASK_W-1:0]     prev_contact;
  logic [TIMER_BITS-1:0] stance_us [NUM_LEGS];
  logic [TIMER_BITS-1:0] noslip_us [NUM_LEGS];
  logic                  slip_held [NUM_LEGS];
  logic [GAIN_W-1:0]     leg_gain  [NUM_LEGS];
  res_t                  tick_results [$];

  function automatic logic [TIMER_BITS-1:0] add_tick_sat(input logic [TIMER_BITS-1:0] t);
    logic [TIMER_BITS:0] sum;
    sum = {1'b0, t} + (TIMER_BITS + 1)'(cfg.tick);
    return sum[TIMER_BITS] ? '1 : sum[TIMER_BITS-1:0];
  endfunction

  function automatic void check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
      mismatch_count_o++;
    end
  endfunction

  // Advances the clock and every leg by one tick and returns the result beat.
  function automatic res_t advance_tick(input logic [MASK_W-1:0] contact,
                                        input logic [MASK_W-1:0] slips);
    res_t              r;
    logic [GAIN_W-1:0] latch_gain;
    logic [MASK_W-1:0] next_contact;
    logic              down;
    logic              was_down;
    logic              slip;
    r = '0;
    next_contact = '0;
    latch_gain = (cfg.sgain > GAIN_ONE) ? GAIN_ONE : cfg.sgain;
    clock_us = clock_us + TIME_W'(cfg.tick);
    for (int i = 0; i < NUM_LEGS; i++) begin
      down = 1'b0;
      was_down = 1'b0;
      slip = 1'b0;
      if (i < MASK_W) begin
        down = contact[i];
        was_down = prev_contact[i];
        slip = slips[i];
        r.liftoff[i] = was_down & ~down;
        r.touchdown[i] = ~was_down & down;
        next_contact[i] = down;
      end
      // Edges and the clock keep running while the friction state is frozen.
      if (!cfg.enable) continue;
      stance_us[i] = down ? add_tick_sat(stance_us[i]) : '0;
      if (slip_held[i] && down) noslip_us[i] = slip ? '0 : add_tick_sat(noslip_us[i]);
      if (slip) begin
        if (33'(stance_us[i]) > 33'(cfg.confirm)) begin
          leg_gain[i] = latch_gain;
          slip_held[i] = 1'b1;
        end
      end else if (down && slip_held[i]) begin
        if (33'(noslip_us[i]) > 33'(cfg.recover)) begin
          leg_gain[i] = GAIN_ONE;
          slip_held[i] = 1'b0;
          noslip_us[i] = '0;
        end
      end
    end
    prev_contact = next_contact;
    r.event_time = clock_us;
    for (int j = 0; j < OUT_LEGS; j++) r.gains[j] = (j < NUM_LEGS) ? leg_gain[j] : GAIN_ONE;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [ADDR_W-3:0] reg_idx;
    logic [DATA_W-1:0] reg_val;
    logic              mapped;
    res_t              want;
    if (!rst_ni) begin
      cfg = '{enable: RST_MOD_ENABLE, sgain: RST_SLIP_GAIN, tick: RST_TICK_US,
              confirm: RST_CONFIRM_US, recover: RST_RECOVER_US};
      clock_us = '0;
      prev_contact = '0;
      for (int i = 0; i < NUM_LEGS; i++) begin
        stance_us[i] = '0;
        noslip_us[i] = '0;
        slip_held[i] = 1'b0;
        leg_gain[i] = GAIN_ONE;
      end
      tick_results.delete();
      mismatch_count_o = 0;
      results_checked_o = 0;
    end else begin
      if (psel && penable && pready) begin
        reg_idx = paddr[ADDR_W-1:2];
        mapped = 1'b1;
        case (reg_idx)
          REG_MOD_ENABLE: reg_val = DATA_W'(cfg.enable);
          REG_SLIP_GAIN:  reg_val = DATA_W'(cfg.sgain);
          REG_TICK_US:    reg_val = DATA_W'(cfg.tick);
          REG_CONFIRM_US: reg_val = DATA_W'(cfg.confirm);
          REG_RECOVER_US: reg_val = DATA_W'(cfg.recover);
          default: begin
            reg_val = '0;
            mapped = 1'b0;
          end
        endcase
        if (pwrite) begin
          case (reg_idx)
            REG_MOD_ENABLE: cfg.enable = pwdata[0];
            REG_SLIP_GAIN:  cfg.sgain = pwdata[GAIN_W-1:0];
            REG_TICK_US:    cfg.tick = pwdata[TICK_W-1:0];
            REG_CONFIRM_US: cfg.confirm = pwdata[CONF_W-1:0];
            REG_RECOVER_US: cfg.recover = pwdata[CONF_W-1:0];
            default: ;
          endcase
        end else if (mapped) begin
          check_field("prdata", 64'(reg_val), 64'(prdata));
        end
      end
      // The result of an older tick leaves before a new tick is predicted.
      if (out_valid_i && out_ready_i) begin
        if (tick_results.size() == 0) begin
          $error("result beat with no tick waiting for it");
          mismatch_count_o++;
        end else begin
          want = tick_results.pop_front();
          check_field("liftoff_mask", 64'(want.liftoff), 64'(liftoff_mask_i));
          check_field("touchdown_mask", 64'(want.touchdown), 64'(touchdown_mask_i));
          check_field("event_time", 64'(want.event_time), 64'(event_time_i));
          check_field("gain_leg0", 64'(want.gains[0]), 64'(gain_leg0_i));
          check_field("gain_leg1", 64'(want.gains[1]), 64'(gain_leg1_i));
          check_field("gain_leg2", 64'(want.gains[2]), 64'(gain_leg2_i));
          check_field("gain_leg3", 64'(want.gains[3]), 64'(gain_leg3_i));
          results_checked_o++;
        end
      end
      if (in_valid_i && in_ready_i)
        tick_results.push_back(advance_tick(grounded_mask_i, slipping_mask_i));
    end
    ticks_in_flight_o = tick_results.size();
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

// Testbench for the leg contact and slip qualifier. This module only makes
// stimulus and gives the verdict; the checker beside the block predicts every
// result beat and counts mismatches.
//
// The run starts with a read-back of the reset register values and a short
// directed walk through the special cases: the first tick after reset, edges
// on every leg, a slip gain above one, a gain of zero, recovery to one, the
// frozen friction state and a zero tick length. Then come random phases, each
// with its own register setting. Most ticks follow a walking gait with bursts
// of slip in stance, so that slip confirmation and recovery are reached; the
// rest are random masks. One phase keeps all legs down long enough for both
// timers to saturate against thresholds just below the maximum.
module tb_top;
  import lcsq_pkg::*;

  localparam int unsigned HALF_PERIOD   = 4;
  localparam int unsigned RESET_CYCLES  = 7;
  localparam int unsigned RANDOM_TICKS  = 1950;
  localparam int unsigned LIMIT_CYCLES  = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 16;
  // A register index past the last one; writes there must change nothing.
  localparam int unsigned UNMAPPED_REG  = 5;
  // Length of the stance walk that drives both timers into saturation.
  localparam int unsigned SAT_WALK      = 270;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [MASK_W-1:0] grounded = '0;
  logic [MASK_W-1:0] slipping = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [MASK_W-1:0] liftoff;
  logic [MASK_W-1:0] touchdown;
  logic [TIME_W-1:0] event_time;
  logic [GAIN_W-1:0] gain_leg0;
  logic [GAIN_W-1:0] gain_leg1;
  logic [GAIN_W-1:0] gain_leg2;
  logic [GAIN_W-1:0] gain_leg3;

  int unsigned mismatches;
  int unsigned ticks_in_flight;
  int unsigned results_checked;
  int unsigned ticks_sent = 0;
  int unsigned settings_written = 0;
  int unsigned cycle_count = 0;
  // While set, neither side inserts idle cycles.
  bit          calm = 1'b0;

  always #(HALF_PERIOD) clk = ~clk;

  leg_contact_slip_qualifier_top DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .grounded_mask_i  (grounded),
    .slipping_mask_i  (slipping),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .liftoff_mask_o   (liftoff),
    .touchdown_mask_o (touchdown),
    .event_time_o     (event_time),
    .gain_leg0_o      (gain_leg0),
    .gain_leg1_o      (gain_leg1),
    .gain_leg2_o      (gain_leg2),
    .gain_leg3_o      (gain_leg3)
  );

  lcsq_checker contact_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .pready            (pready),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .grounded_mask_i   (grounded),
    .slipping_mask_i   (slipping),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .liftoff_mask_i    (liftoff),
    .touchdown_mask_i  (touchdown),
    .event_time_i      (event_time),
    .gain_leg0_i       (gain_leg0),
    .gain_leg1_i       (gain_leg1),
    .gain_leg2_i       (gain_leg2),
    .gain_leg3_i       (gain_leg3),
    .mismatch_count_o  (mismatches),
    .ticks_in_flight_o (ticks_in_flight),
    .results_checked_o (results_checked)
  );

  // Idle length for either side: mostly none or a few cycles, now and then a
  // long one that fills the output buffer or drains it completely.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // One APB transfer, entered and left at a falling edge: a setup cycle, then
  // an access cycle that completes at the rising edge where pready is high.
  task automatic apb_access(input logic write, input int unsigned index,
                            input logic [DATA_W-1:0] data);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = write;
    paddr = ADDR_W'(index * 4);
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Writes a register and reads it straight back; the checker compares the
  // read data with its own copy.
  task automatic set_reg(input int unsigned index, input logic [DATA_W-1:0] data);
    apb_access(1'b1, index, data);
    apb_access(1'b0, index, '0);
  endtask

  // Drops valid and waits until every tick sent so far has its result beat.
  task automatic drain_results();
    in_valid = 1'b0;
    while (ticks_in_flight != 0) @(negedge clk);
  endtask

  // Registers change only while the block is idle.
  task automatic configure(input logic en, input logic [GAIN_W-1:0] sgain,
                           input logic [TICK_W-1:0] tick, input logic [CONF_W-1:0] confirm,
                           input logic [CONF_W-1:0] recover);
    drain_results();
    set_reg(REG_MOD_ENABLE, DATA_W'(en));
    set_reg(REG_SLIP_GAIN, DATA_W'(sgain));
    set_reg(REG_TICK_US, DATA_W'(tick));
    set_reg(REG_CONFIRM_US, DATA_W'(confirm));
    set_reg(REG_RECOVER_US, DATA_W'(recover));
    settings_written++;
  endtask

  // Sends one tick beat, after an optional idle gap. Valid stays high on
  // return so that back-to-back beats never drop it for a step.
  task automatic send_tick(input logic [MASK_W-1:0] contact, input logic [MASK_W-1:0] slips);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    grounded = contact;
    slipping = slips;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    ticks_sent++;
  endtask

  // The result side alternates runs of ready with stalls of random length.
  initial begin : result_sink
    int unsigned stall;
    @(posedge rst_n);
    forever begin
      out_ready = 1'b1;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(50, 200) : $urandom_range(1, 20))
        @(negedge clk);
      stall = pick_gap();
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d ticks sent.", cycle_count, ticks_sent);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned       random_sent;
    int unsigned       phase_len;
    int unsigned       slip_pct;
    int unsigned       max_stance;
    int unsigned       stance_left [MASK_W];
    int unsigned       air_left    [MASK_W];
    int unsigned       burst_left  [MASK_W];
    logic [MASK_W-1:0] contact;
    logic [MASK_W-1:0] slips;
    logic [TICK_W-1:0] tick;
    logic [63:0]       span;
    logic [CONF_W-1:0] confirm;
    logic [CONF_W-1:0] recover;

    random_sent = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset values of every register.
    for (int r = REG_MOD_ENABLE; r <= REG_RECOVER_US; r++) apb_access(1'b0, r, '0);

    // First tick after reset: every grounded leg reports a touch-down.
    send_tick(4'hF, 4'h0);
    send_tick(4'h0, 4'hF);
    send_tick(4'h5, 4'h0);
    send_tick(4'hA, 4'h5);

    // A write past the last register must leave the settings alone.
    drain_results();
    set_reg(UNMAPPED_REG, '1);

    // A slip gain above one is clipped to one when latched.
    configure(1'b1, 16'hFFFF, 16'd10000, 24'd15000, 24'd25000);
    send_tick(4'hF, 4'h0);
    send_tick(4'hF, 4'hF);

    // Zero gain on slip, then recovery to one after enough slip-free stance.
    configure(1'b1, 16'd0, 16'd10000, 24'd15000, 24'd25000);
    send_tick(4'hF, 4'hF);
    send_tick(4'hF, 4'h0);
    send_tick(4'hF, 4'h0);
    send_tick(4'hF, 4'h0);
    send_tick(4'hF, 4'h3);

    // Frozen friction state: edges and the clock still move.
    configure(1'b0, 16'd0, 16'd10000, 24'd15000, 24'd25000);
    send_tick(4'h0, 4'hF);
    send_tick(4'hF, 4'h0);

    // Zero tick length: clock and timers stand still.
    configure(1'b1, GAIN_ONE, 16'd0, 24'd0, 24'd0);
    send_tick(4'hF, 4'hC);
    send_tick(4'hF, 4'h0);
    send_tick(4'h6, 4'h9);

    for (int phase = 0; random_sent < RANDOM_TICKS; phase++) begin
      slip_pct = 10;
      max_stance = 16;
      case (phase)
        0: configure(1'b1, 16'd0, 16'hFFFF, 24'd0, 24'd0);
        1: configure(1'b1, GAIN_ONE, 16'd1, 24'hFFFFFF, 24'hFFFFFF);
        2: configure(1'b0, GAIN_W'($urandom), TICK_W'($urandom), CONF_W'($urandom),
                     CONF_W'($urandom));
        3: configure(1'b1, 16'hFFFF, 16'hFFFF, 24'hFFFFFE, 24'hFFFFFE);
        4: configure(1'b1, GAIN_W'($urandom_range(0, 32768)), 16'd0,
                     CONF_W'($urandom_range(0, 3)), CONF_W'($urandom_range(0, 3)));
        default: begin
          // Thresholds near a multiple of the tick so that slip confirmation
          // and recovery fall inside ordinary stance lengths.
          tick = ($urandom_range(0, 9) == 0) ? TICK_W'($urandom_range(0, 65535))
                                             : TICK_W'($urandom_range(1, 4000));
          span = 64'(tick) * $urandom_range(0, 10) + $urandom_range(0, tick);
          confirm = (span > 64'hFFFFFF) ? '1 : span[CONF_W-1:0];
          span = 64'(tick) * $urandom_range(0, 16) + $urandom_range(0, tick);
          recover = (span > 64'hFFFFFF) ? '1 : span[CONF_W-1:0];
          configure($urandom_range(0, 7) != 0,
                    ($urandom_range(0, 3) == 0) ? GAIN_W'($urandom)
                                                : GAIN_W'($urandom_range(0, 32768)),
                    tick, confirm, recover);
          slip_pct = $urandom_range(2, 25);
          max_stance = $urandom_range(4, 30);
        end
      endcase
      calm = (phase % 4 == 3);
      for (int leg = 0; leg < MASK_W; leg++) begin
        stance_left[leg] = 0;
        air_left[leg] = $urandom_range(1, 3);
        burst_left[leg] = 0;
      end

      if (phase == 3) begin
        // All legs down with the longest tick: the stance timer saturates just
        // above the confirm time, one slip latches, and the no-slip timer then
        // saturates just above the recovery time.
        for (int n = 0; n < 2 * SAT_WALK + 1; n++) begin
          send_tick(4'hF, (n == SAT_WALK) ? 4'hF : 4'h0);
          random_sent++;
        end
      end else begin
        phase_len = $urandom_range(80, 200);
        for (int n = 0; n < phase_len && random_sent < RANDOM_TICKS; n++) begin
          if ($urandom_range(0, 99) < 15) begin
            contact = MASK_W'($urandom);
            slips = MASK_W'($urandom);
          end else begin
            // Walking gait: stance spells with short slip bursts, short flights
            // with an occasional stray slip bit.
            for (int leg = 0; leg < MASK_W; leg++) begin
              if (stance_left[leg] != 0) begin
                contact[leg] = 1'b1;
                stance_left[leg]--;
                if (burst_left[leg] == 0 && $urandom_range(0, 99) < slip_pct)
                  burst_left[leg] = $urandom_range(1, 4);
                slips[leg] = (burst_left[leg] != 0);
                if (burst_left[leg] != 0) burst_left[leg]--;
                if (stance_left[leg] == 0) air_left[leg] = $urandom_range(1, 4);
              end else begin
                contact[leg] = 1'b0;
                slips[leg] = ($urandom_range(0, 19) == 0);
                if (air_left[leg] > 1) air_left[leg]--;
                else stance_left[leg] = $urandom_range(1, max_stance);
              end
            end
          end
          send_tick(contact, slips);
          random_sent++;
          // Now and then the sender holds off until the block has emptied.
          if ($urandom_range(0, 199) == 0) drain_results();
        end
      end
    end

    drain_results();
    calm = 1'b0;
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Covered %0d ticks over %0d register settings, with gait, slip and saturation runs.",
             ticks_sent, settings_written);
    $display("%0d result beats compared, %0d mismatching fields.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
design/lcsq_pkg.sv
design/lcsq_lane.sv
design/lcsq_outbuf.sv
design/leg_contact_slip_qualifier_top.sv
verif/lcsq_checker.sv
verif/tb_top.sv
